@@ sv/bdc_pkg.sv @@
// Shared constants for the Bezier de Casteljau sampler: field widths, command
// and register codes, fixed-point format. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdc_pkg;

  // Register file
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'd1;

  localparam int PC_W = 4;
  localparam int SC_W = 7;
  localparam logic [PC_W-1:0] PC_RESET = 4'd4;
  localparam logic [SC_W-1:0] SC_RESET = 7'd20;

  // Input and output field widths
  localparam int PIDX_W = 3;
  localparam int SIDX_W = 6;

  // Commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // Coordinate being worked on
  localparam int AXIS_W = 2;
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // Curve parameter u: unsigned, 16 fraction bits, 0..1.0 inclusive
  localparam int FRAC_W     = 16;
  localparam int U_W        = FRAC_W + 1;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);
  localparam int DIV_CNT_W  = $clog2(U_W);

endpackage

`default_nettype wire

@@ sv/bdc_lerp.sv @@
// Shared interpolation unit: r = a + round(u * (b - a) / 2^16), saturated.
// Two stages: multiply into a register, then round, add and clamp.
// Depends on bdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdc_lerp #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          issue,
  input  logic signed [COORD_WIDTH-1:0] a,
  input  logic signed [COORD_WIDTH-1:0] b,
  input  logic [bdc_pkg::U_W-1:0]       u,
  output logic                          push,
  output logic signed [COORD_WIDTH-1:0] result
);

  import bdc_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = DW + U_W + 1;
  localparam int RW = PW - FRAC_W;
  localparam logic signed [RW-1:0] SAT_HI =
    {{(RW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO =
    {{(RW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

  logic signed [DW-1:0]          diff;
  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          prod_r;
  logic signed [COORD_WIDTH-1:0] a_r;
  logic                          v_r;
  logic signed [PW-1:0]          rnd_sum;
  logic signed [RW-1:0]          rnd;
  logic signed [RW-1:0]          sum;

  assign diff = {b[COORD_WIDTH-1], b} - {a[COORD_WIDTH-1], a};
  assign prod = $signed({1'b0, u}) * diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= prod;
      a_r    <= a;
    end
  end

  // floor((p + half) / 2^16) is an arithmetic shift of the rounded product
  assign rnd_sum = prod_r + $signed(PW'(ROUND_HALF));
  assign rnd     = rnd_sum[PW-1:FRAC_W];
  assign sum     = {{(RW - COORD_WIDTH){a_r[COORD_WIDTH-1]}}, a_r} + rnd;

  always_comb begin
    priority if (sum > SAT_HI) begin
      result = SAT_HI[COORD_WIDTH-1:0];
    end else if (sum < SAT_LO) begin
      result = SAT_LO[COORD_WIDTH-1:0];
    end else begin
      result = sum[COORD_WIDTH-1:0];
    end
  end

  assign push = v_r;

endmodule

`default_nettype wire

@@ sv/bezier_de_casteljau_sampler.sv @@
// Top level of the Bezier de Casteljau sampler: control point store, u
// sequencer with divider, de Casteljau queue and register port.
// Depends on bdc_pkg and bdc_lerp.
//
//   channel   | ports                                    | flow control
//   ----------+------------------------------------------+----------------------
//   command   | start, busy, in_command .. in_coord_z    | transfer: start & !busy
//   result    | out_strobe, out_sample_index .. last     | one-cycle strobe
//   config    | psel, penable, pwrite, paddr, pwdata ..  | APB, pready tied high
//
// A load leaves busy low. A run for n control points and S samples does a
// bit-serial divide that finds the u step, fills the queue, then per sample
// and axis walks the de Casteljau triangle through the shared multiplier
// and ends with a capture step. The last strobe comes in the first cycle
// with busy low. rst_n is synchronous; the store is not cleared, and reading
// a never-written slot gives whatever it holds. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module bezier_de_casteljau_sampler #(
  parameter int MAX_POINTS  = 8,
  parameter int MAX_SAMPLES = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic [bdc_pkg::PIDX_W-1:0]         in_point_index,
  input  logic signed [COORD_WIDTH-1:0]      in_coord_x,
  input  logic signed [COORD_WIDTH-1:0]      in_coord_y,
  input  logic signed [COORD_WIDTH-1:0]      in_coord_z,
  // result channel
  output logic                               out_strobe,
  output logic [bdc_pkg::SIDX_W-1:0]         out_sample_index,
  output logic signed [COORD_WIDTH-1:0]      out_curve_x,
  output logic signed [COORD_WIDTH-1:0]      out_curve_y,
  output logic signed [COORD_WIDTH-1:0]      out_curve_z,
  output logic                               out_last_sample,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bdc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [bdc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  import bdc_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DEN_W = $clog2(MAX_SAMPLES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_POP  = 3'd3;
  localparam logic [2:0] ST_CAPT = 3'd4;

  // ---------------------------------------------------------------- registers
  logic [PC_W-1:0] cfg_pc_r;
  logic [SC_W-1:0] cfg_sc_r;
  logic            cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1 -: REG_IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pc_r <= PC_RESET;
      cfg_sc_r <= SC_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_POINT_COUNT:  cfg_pc_r <= pwdata[PC_W-1:0];
        REG_SAMPLE_COUNT: cfg_sc_r <= pwdata[SC_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POINT_COUNT:  prdata = {{(CFG_DATA_W - PC_W){1'b0}}, cfg_pc_r};
      REG_SAMPLE_COUNT: prdata = {{(CFG_DATA_W - SC_W){1'b0}}, cfg_sc_r};
    endcase
  end

  // ---------------------------------------------------------- control store
  logic signed [COORD_WIDTH-1:0] store_x_r [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] store_y_r [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] store_z_r [MAX_POINTS];
  logic in_take;
  logic store_we;

  assign in_take  = start && !busy;
  // drop loads aimed past the last slot
  assign store_we = in_take && (in_command == CMD_LOAD) &&
                    (32'(in_point_index) < MAX_POINTS);

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_x_r[IDX_W'(in_point_index)] <= in_coord_x;
      store_y_r[IDX_W'(in_point_index)] <= in_coord_y;
      store_z_r[IDX_W'(in_point_index)] <= in_coord_z;
    end
  end

  // --------------------------------------------------------------- sequencer
  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;          // control points this run
  logic [DEN_W-1:0]       den_r, den_nxt;      // samples minus one
  logic [DEN_W-1:0]       rem_r, rem_nxt;      // divider remainder, then step remainder
  logic [U_W-1:0]         quot_r, quot_nxt;    // divider quotient, then step quotient
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [U_W-1:0]         u_r, u_nxt;
  logic [DEN_W-1:0]       u_rem_r, u_rem_nxt;
  logic [DEN_W-1:0]       i_r, i_nxt;
  logic [AXIS_W-1:0]      c_r, c_nxt;
  logic [CNT_W-1:0]       m_r, m_nxt;          // width of current triangle level
  logic [CNT_W-1:0]       j_r, j_nxt;          // position inside the level
  logic signed [COORD_WIDTH-1:0] q_r [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] q_nxt [MAX_POINTS];
  logic [CNT_W-1:0]       q_cnt_r, q_cnt_nxt;
  logic signed [COORD_WIDTH-1:0] res_x_r, res_y_r;

  logic                   out_strobe_r, out_strobe_nxt;
  logic [SIDX_W-1:0]      out_idx_r;
  logic signed [COORD_WIDTH-1:0] out_x_r, out_y_r, out_z_r;
  logic                   out_last_r;

  logic [CNT_W-1:0]       n_run;
  logic [DEN_W-1:0]       den_run;
  logic [DEN_W:0]         div_shift;
  logic                   div_ge;
  logic [DEN_W:0]         div_sub;
  logic [DEN_W:0]         u_rr;
  logic                   u_ge;
  logic [DEN_W:0]         u_sub;
  logic                   load_queue;
  logic                   capture;
  logic                   lerp_issue;
  logic                   lerp_push;
  logic signed [COORD_WIDTH-1:0] lerp_res;
  logic [CNT_W-1:0]       m_last;

  // clamp the registers to the supported range at run start
  always_comb begin
    priority if (cfg_pc_r < PC_W'(2)) begin
      n_run = CNT_W'(2);
    end else if (32'(cfg_pc_r) > MAX_POINTS) begin
      n_run = CNT_W'(MAX_POINTS);
    end else begin
      n_run = CNT_W'(cfg_pc_r);
    end
    priority if (cfg_sc_r < SC_W'(2)) begin
      den_run = DEN_W'(1);
    end else if (32'(cfg_sc_r) > MAX_SAMPLES) begin
      den_run = DEN_W'(MAX_SAMPLES - 1);
    end else begin
      den_run = DEN_W'(cfg_sc_r - SC_W'(1));
    end
  end

  // restoring divide of 2^16 by den, one quotient bit a cycle
  assign div_shift = {rem_r, (div_cnt_r == DIV_CNT_W'(U_W - 1))};
  assign div_ge    = div_shift >= {1'b0, den_r};
  assign div_sub   = div_shift - {1'b0, den_r};

  // next u = u + 2^16/den, carrying the remainder
  assign u_rr  = {1'b0, u_rem_r} + {1'b0, rem_r};
  assign u_ge  = u_rr >= {1'b0, den_r};
  assign u_sub = u_rr - {1'b0, den_r};

  assign m_last     = m_r - CNT_W'(1);
  assign lerp_issue = (state_r == ST_POP) && (j_r != m_last);

  bdc_lerp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_lerp (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (lerp_issue),
    .a      (q_r[0]),
    .b      (q_r[1]),
    .u      (u_r),
    .push   (lerp_push),
    .result (lerp_res)
  );

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    quot_nxt       = quot_r;
    div_cnt_nxt    = div_cnt_r;
    u_nxt          = u_r;
    u_rem_nxt      = u_rem_r;
    i_nxt          = i_r;
    c_nxt          = c_r;
    m_nxt          = m_r;
    j_nxt          = j_r;
    q_nxt          = q_r;
    q_cnt_nxt      = q_cnt_r;
    out_strobe_nxt = 1'b0;
    load_queue     = 1'b0;
    capture        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take && (in_command == CMD_RUN)) begin
          state_nxt   = ST_DIV;
          n_nxt       = n_run;
          den_nxt     = den_run;
          rem_nxt     = '0;
          quot_nxt    = '0;
          div_cnt_nxt = DIV_CNT_W'(U_W - 1);
        end
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? div_sub[DEN_W-1:0] : div_shift[DEN_W-1:0];
        quot_nxt = {quot_r[U_W-2:0], div_ge};
        if (div_cnt_r == '0) begin
          state_nxt = ST_LOAD;
          u_nxt     = '0;
          u_rem_nxt = den_r >> 1;
          i_nxt     = '0;
          c_nxt     = AXIS_X;
        end else begin
          div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
        end
      end
      ST_LOAD: begin
        load_queue = 1'b1;
        state_nxt  = ST_POP;
      end
      ST_POP: begin
        // pop the head every cycle; a finished interpolation lands at the tail
        for (int k = 0; k < MAX_POINTS - 1; k++) begin
          q_nxt[k] = q_r[k + 1];
        end
        if (lerp_push) begin
          q_nxt[IDX_W'(q_cnt_r - CNT_W'(1))] = lerp_res;
        end
        q_cnt_nxt = q_cnt_r - CNT_W'(1) + CNT_W'(lerp_push);
        if (j_r == m_last) begin
          // level done: its last old entry is the one just dropped
          if (m_r == CNT_W'(2)) begin
            state_nxt = ST_CAPT;
          end else begin
            m_nxt = m_last;
            j_nxt = '0;
          end
        end else begin
          j_nxt = j_r + CNT_W'(1);
        end
      end
      ST_CAPT: begin
        capture = 1'b1;
        if (c_r != AXIS_Z) begin
          c_nxt      = c_r + AXIS_W'(1);
          load_queue = 1'b1;
          state_nxt  = ST_POP;
        end else begin
          out_strobe_nxt = 1'b1;
          u_nxt     = u_r + quot_r + U_W'(u_ge);
          u_rem_nxt = u_ge ? u_sub[DEN_W-1:0] : u_rr[DEN_W-1:0];
          if (i_r == den_r) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt      = i_r + DEN_W'(1);
            c_nxt      = AXIS_X;
            load_queue = 1'b1;
            state_nxt  = ST_POP;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // fill the queue with the control points of the next axis
    if (load_queue) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        unique case (c_nxt)
          AXIS_X:  q_nxt[k] = store_x_r[k];
          AXIS_Y:  q_nxt[k] = store_y_r[k];
          default: q_nxt[k] = store_z_r[k];
        endcase
      end
      q_cnt_nxt = n_r;
      m_nxt     = n_r;
      j_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      div_cnt_r    <= '0;
      i_r          <= '0;
      c_r          <= AXIS_X;
      m_r          <= '0;
      j_r          <= '0;
      q_cnt_r      <= '0;
      n_r          <= CNT_W'(2);
      den_r        <= DEN_W'(1);
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      div_cnt_r    <= div_cnt_nxt;
      i_r          <= i_nxt;
      c_r          <= c_nxt;
      m_r          <= m_nxt;
      j_r          <= j_nxt;
      q_cnt_r      <= q_cnt_nxt;
      n_r          <= n_nxt;
      den_r        <= den_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
    u_r     <= u_nxt;
    u_rem_r <= u_rem_nxt;
    q_r     <= q_nxt;
    if (capture && (c_r == AXIS_X)) begin
      res_x_r <= q_r[0];
    end
    if (capture && (c_r == AXIS_Y)) begin
      res_y_r <= q_r[0];
    end
    if (out_strobe_nxt) begin
      out_idx_r  <= SIDX_W'(i_r);
      out_x_r    <= res_x_r;
      out_y_r    <= res_y_r;
      out_z_r    <= q_r[0];
      out_last_r <= (i_r == den_r);
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_sample_index = out_idx_r;
  assign out_curve_x      = out_x_r;
  assign out_curve_y      = out_y_r;
  assign out_curve_z      = out_z_r;
  assign out_last_sample  = out_strobe_r && out_last_r;

  // ---------------------------------------------------------------- checks
  // an interpolation result only lands while the queue is popping
  a_push_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
    lerp_push |-> (state_r == ST_POP))
    else $error("interpolation result outside pop phase");

  // the queue never holds more than the active control points, never empties mid-level
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> ((q_cnt_r <= n_r) && (q_cnt_r != '0)))
    else $error("queue fill out of range");

  // a run command raises busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == CMD_RUN)) |=> busy)
    else $error("run transfer did not raise busy");

  // strobes never come back to back: each sample first passes through the pop and capture states
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

endmodule

`default_nettype wire
